[rtl/core/dsd_pkg.sv]
// ----------------------------------------------------------------------------
// dsd_pkg: shared types and constants for the drink session detector
// Session phase codes, event codes, register indexes and the structs that
// pass between the top level and the per-sample step logic.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int WEIGHT_W = 21;
    localparam int TICK_W   = 32;
    localparam int CFG_W    = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DWELL   = 2'd0;
    localparam logic [1:0] REG_STOP    = 2'd1;
    localparam logic [1:0] REG_SPLASH  = 2'd2;
    localparam logic [1:0] REG_INTAKE  = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] DWELL_RST  = 16'd5000;
    localparam logic [CFG_W-1:0] STOP_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] SPLASH_RST = 16'd500;
    localparam logic [CFG_W-1:0] INTAKE_RST = 16'd10;

    // Spike count saturates here; reaching it raises the splash fault
    localparam logic [1:0] SPIKE_MAX = 2'd3;

    // Phase codes as seen on the result
    localparam logic [1:0] PHC_IDLE   = 2'd0;
    localparam logic [1:0] PHC_VERIFY = 2'd1;
    localparam logic [1:0] PHC_STABLE = 2'd2;
    localparam logic [1:0] PHC_STOP   = 2'd3;

    // Event codes
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_VERIFIED = 2'd1;
    localparam logic [1:0] EV_DRINK    = 2'd2;
    localparam logic [1:0] EV_FAULT    = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_VERIFY = 4'b0010,
        PH_STABLE = 4'b0100,
        PH_STOP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] dwell_ticks;
        logic [CFG_W-1:0] stop_ticks;
        logic [CFG_W-1:0] splash_delta;
        logic [CFG_W-1:0] intake_threshold;
    } cfg_t;

    typedef struct packed {
        logic                       presence;
        logic signed [WEIGHT_W-1:0] weight;
        logic [TICK_W-1:0]          now_tick;
    } sample_t;

    typedef struct packed {
        phase_t                     phase;
        logic [TICK_W-1:0]          deadline;
        logic signed [WEIGHT_W-1:0] start_mass;
        logic [1:0]                 spike_count;
        logic                       fault_flag;
    } state_t;

    typedef struct packed {
        logic [1:0]                 phase;
        logic [1:0]                 event_res;
        logic signed [WEIGHT_W-1:0] begin_weight;
        logic signed [WEIGHT_W-1:0] final_weight;
        logic [WEIGHT_W-1:0]        intake;
        logic                       splash_fault;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_IDLE:   code = PHC_IDLE;
            PH_VERIFY: code = PHC_VERIFY;
            PH_STABLE: code = PHC_STABLE;
            PH_STOP:   code = PHC_STOP;
            default:   code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/dsd_step.sv]
// ----------------------------------------------------------------------------
// dsd_step: per-sample session update
// Combinational next state and result for one poll sample.
// ----------------------------------------------------------------------------
module dsd_step (
    input  dsd_pkg::cfg_t    cfg,
    input  dsd_pkg::state_t  st,
    input  dsd_pkg::sample_t smp,
    output dsd_pkg::state_t  st_next,
    output dsd_pkg::result_t res
);

    logic signed [dsd_pkg::WEIGHT_W:0] diff;
    logic [dsd_pkg::WEIGHT_W:0]        mag;
    logic signed [dsd_pkg::WEIGHT_W:0] drop;
    logic [dsd_pkg::TICK_W-1:0]        dl_diff;
    logic                              reached;
    logic                              spike_hit;
    logic                              drop_ok;
    logic [1:0]                        spike_sat;

    assign diff = {smp.weight[dsd_pkg::WEIGHT_W-1], smp.weight}
                - {st.start_mass[dsd_pkg::WEIGHT_W-1], st.start_mass};
    assign mag  = diff[dsd_pkg::WEIGHT_W] ? (~diff + 1'b1) : diff;
    assign spike_hit = mag >= {{(dsd_pkg::WEIGHT_W + 1 - dsd_pkg::CFG_W){1'b0}},
                               cfg.splash_delta};
    assign spike_sat = (st.spike_count == dsd_pkg::SPIKE_MAX)
                     ? st.spike_count : st.spike_count + 2'd1;

    // Positive drop that strictly exceeds the threshold
    assign drop = {st.start_mass[dsd_pkg::WEIGHT_W-1], st.start_mass}
                - {smp.weight[dsd_pkg::WEIGHT_W-1], smp.weight};
    assign drop_ok = !drop[dsd_pkg::WEIGHT_W] && (drop != '0)
                   && (drop[dsd_pkg::WEIGHT_W-1:0]
                       > {{(dsd_pkg::WEIGHT_W - dsd_pkg::CFG_W){1'b0}},
                          cfg.intake_threshold});

    // Wrap-safe: reached when (deadline - now) read signed is <= 0
    assign dl_diff = st.deadline - smp.now_tick;
    assign reached = (dl_diff == '0) || dl_diff[dsd_pkg::TICK_W-1];

    always_comb
    begin
        st_next = st;
        res     = '0;
        case (st.phase)
            dsd_pkg::PH_IDLE:
            begin
                if (smp.presence)
                begin
                    st_next.spike_count = '0;
                    st_next.fault_flag  = 1'b0;
                    st_next.start_mass  = smp.weight;
                    st_next.deadline    = smp.now_tick
                        + {{(dsd_pkg::TICK_W - dsd_pkg::CFG_W){1'b0}}, cfg.dwell_ticks};
                    st_next.phase       = dsd_pkg::PH_VERIFY;
                end
            end
            dsd_pkg::PH_VERIFY:
            begin
                if (!smp.presence)
                begin
                    st_next.phase = dsd_pkg::PH_IDLE;
                end
                else if (spike_hit && (spike_sat == dsd_pkg::SPIKE_MAX))
                begin
                    st_next.spike_count = spike_sat;
                    st_next.start_mass  = smp.weight;
                    st_next.phase       = dsd_pkg::PH_IDLE;
                    st_next.fault_flag  = 1'b1;
                    res.event_res       = dsd_pkg::EV_FAULT;
                end
                else
                begin
                    if (spike_hit)
                    begin
                        st_next.spike_count = spike_sat;
                        st_next.start_mass  = smp.weight;
                    end
                    if (reached)
                    begin
                        res.event_res    = dsd_pkg::EV_VERIFIED;
                        res.begin_weight = st_next.start_mass;
                        st_next.phase    = dsd_pkg::PH_STABLE;
                    end
                end
            end
            dsd_pkg::PH_STABLE:
            begin
                if (!smp.presence)
                begin
                    st_next.deadline = smp.now_tick
                        + {{(dsd_pkg::TICK_W - dsd_pkg::CFG_W){1'b0}}, cfg.stop_ticks};
                    st_next.phase    = dsd_pkg::PH_STOP;
                end
            end
            default:
            begin
                if (smp.presence)
                begin
                    st_next.phase = dsd_pkg::PH_STABLE;
                end
                else if (reached)
                begin
                    st_next.phase = dsd_pkg::PH_IDLE;
                    if (drop_ok)
                    begin
                        res.event_res    = dsd_pkg::EV_DRINK;
                        res.begin_weight = st.start_mass;
                        res.final_weight = smp.weight;
                        res.intake       = drop[dsd_pkg::WEIGHT_W-1:0];
                    end
                end
            end
        endcase
        res.phase        = dsd_pkg::phase_code(st_next.phase);
        res.splash_fault = st_next.fault_flag;
    end

endmodule

[rtl/core/drink_session_detector_top.sv]
// ----------------------------------------------------------------------------
// drink_session_detector_top: drink session detector
// Watches presence and load-cell samples, tracks a verify/stable/stop
// session and reports verified sessions, intake and splash faults.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  -------   ---  ---------------------  -------------------------------------
//  s_*       in   s_tvalid / s_tready    presence, weight, now_tick
//  m_*       out  m_tvalid / m_tready    phase, event_res, begin/end weight,
//                                        intake, splash_fault
//  cfg_*     in   cfg_we (no wait)       cfg_index, cfg_data
//
//  Two register stages: a sample register and a result register. A sample
//  is taken into the sample register, then moves into the result register,
//  where its result is shown; one transaction per cycle is sustained while
//  m_tready stays high. The session state updates when a sample moves from
//  the sample register into the result register, so the whole update is one
//  pass of step logic (a 22-bit subtract and compare, a 32-bit deadline
//  add/subtract). A stalled result holds its sample register; the input side
//  keeps taking a transaction while the sample register is empty. rst_n
//  clears the session state and loads register defaults; there is no clearing pass.
//
module drink_session_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [0] presence, [21:1] weight, [53:22] now_tick
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] phase, [3:2] event_res, [24:4] begin_weight,
                                   // [45:25] final_weight, [66:46] intake, [67] splash_fault
);

    dsd_pkg::cfg_t    cfg_reg;
    dsd_pkg::cfg_t    cfg_next;
    dsd_pkg::state_t  st_reg;
    dsd_pkg::state_t  st_next;
    dsd_pkg::sample_t smp_reg;
    dsd_pkg::sample_t smp_in;
    dsd_pkg::result_t res;
    dsd_pkg::result_t res_reg;
    logic             smp_vld_reg;
    logic             smp_vld_next;
    logic             out_vld_reg;
    logic             out_vld_next;
    logic             advance;
    logic             s_take;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                dsd_pkg::REG_DWELL:  cfg_next.dwell_ticks      = cfg_data;
                dsd_pkg::REG_STOP:   cfg_next.stop_ticks       = cfg_data;
                dsd_pkg::REG_SPLASH: cfg_next.splash_delta     = cfg_data;
                dsd_pkg::REG_INTAKE: cfg_next.intake_threshold = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: sample register moves on when the result slot is free
    // or is being drained this cycle.
    // ------------------------------------------------------------------
    assign advance  = smp_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !smp_vld_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign smp_vld_next = s_take || (smp_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !m_tready);

    assign smp_in.presence = s_tdata[0];
    assign smp_in.weight   = s_tdata[21:1];
    assign smp_in.now_tick = s_tdata[53:22];

    dsd_step u_step (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .smp     (smp_reg),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_ticks      <= dsd_pkg::DWELL_RST;
            cfg_reg.stop_ticks       <= dsd_pkg::STOP_RST;
            cfg_reg.splash_delta     <= dsd_pkg::SPLASH_RST;
            cfg_reg.intake_threshold <= dsd_pkg::INTAKE_RST;
            st_reg.phase             <= dsd_pkg::PH_IDLE;
            st_reg.deadline          <= '0;
            st_reg.start_mass        <= '0;
            st_reg.spike_count       <= '0;
            st_reg.fault_flag        <= 1'b0;
            smp_vld_reg              <= 1'b0;
            out_vld_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            smp_vld_reg <= smp_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                st_reg <= st_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            smp_reg <= smp_in;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0000,
                       res_reg.splash_fault,
                       res_reg.intake,
                       res_reg.final_weight,
                       res_reg.begin_weight,
                       res_reg.event_res,
                       res_reg.phase};

`ifndef SYNTHESIS
    // A verified session always lands in the stable phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.event_res == dsd_pkg::EV_VERIFIED)
            |-> (res_reg.phase == dsd_pkg::PHC_STABLE))
        else $error("verified event outside stable phase");

    // A splash fault returns to idle with the fault flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.event_res == dsd_pkg::EV_FAULT)
            |-> (res_reg.splash_fault && res_reg.phase == dsd_pkg::PHC_IDLE))
        else $error("splash fault event without fault flag or idle phase");

    // Reported intake is the start weight minus the end weight
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.event_res == dsd_pkg::EV_DRINK)
            |-> (res_reg.intake == res_reg.begin_weight - res_reg.final_weight))
        else $error("intake does not match weight drop");

    // Input side only stalls when a sample waits behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (smp_vld_reg && m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // Session state only changes when a sample is consumed
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(st_reg))
        else $error("session state changed without a sample");
`endif

endmodule

[sim/drink_session_detector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drink_session_detector_top_tb: self-checking bench for the session detector
// Drives poll samples with random gaps on both streams and predicts every
// result transaction with a cycle-free model of the session machine.
// Directed samples cover boundaries first. Random traffic is steered by the
// predicted phase so most sessions verify, stop and end, across several
// register settings.
// ----------------------------------------------------------------------------
module drink_session_detector_top_tb;

    localparam int          CYCLE_LIMIT = 200000;
    localparam logic [20:0] W_MAX       = 21'h0FFFFF;
    localparam logic [20:0] W_MIN       = 21'h100000;

    // ------------------------------------------------------------------------
    // Session predictor and result scoreboard
    // ------------------------------------------------------------------------
    class session_scoreboard;
        dsd_pkg::cfg_t      regs;
        logic [1:0]         ses_phase;
        logic [31:0]        due;
        logic signed [20:0] start_w;
        logic [1:0]         spikes;
        logic               fault;
        dsd_pkg::result_t   pending_results[$];
        int                 mismatch_count;

        function new();
            regs           = '{dsd_pkg::DWELL_RST, dsd_pkg::STOP_RST,
                               dsd_pkg::SPLASH_RST, dsd_pkg::INTAKE_RST};
            ses_phase      = dsd_pkg::PHC_IDLE;
            due            = '0;
            start_w        = '0;
            spikes         = '0;
            fault          = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                dsd_pkg::REG_DWELL:  regs.dwell_ticks      = val;
                dsd_pkg::REG_STOP:   regs.stop_ticks       = val;
                dsd_pkg::REG_SPLASH: regs.splash_delta     = val;
                dsd_pkg::REG_INTAKE: regs.intake_threshold = val;
                default:    ;
            endcase
        endfunction

        // Wrap-safe: reached when (deadline - now) is zero or negative
        function bit due_reached(logic [31:0] dl, logic [31:0] now);
            logic [31:0] left;
            left = dl - now;
            return (left == '0) || left[31];
        endfunction

        // Advance the session by one accepted sample, queue its result
        function void note_sample(dsd_pkg::sample_t s);
            logic signed [21:0] diff;
            logic signed [21:0] drop;
            logic [21:0]        mag;
            bit                 faulted;
            dsd_pkg::result_t   r;
            r       = '0;
            faulted = 1'b0;
            case (ses_phase)
                dsd_pkg::PHC_IDLE: begin
                    if (s.presence) begin
                        spikes    = '0;
                        fault     = 1'b0;
                        start_w   = s.weight;
                        due       = s.now_tick + {16'd0, regs.dwell_ticks};
                        ses_phase = dsd_pkg::PHC_VERIFY;
                    end
                end
                dsd_pkg::PHC_VERIFY: begin
                    if (!s.presence) begin
                        ses_phase = dsd_pkg::PHC_IDLE;
                    end
                    else begin
                        diff = {s.weight[20], s.weight} - {start_w[20], start_w};
                        mag  = diff[21] ? -diff : diff;
                        if (mag >= {6'd0, regs.splash_delta}) begin
                            if (spikes != dsd_pkg::SPIKE_MAX)
                                spikes = spikes + 2'd1;
                            start_w = s.weight;
                            // third spike: fault wins over the deadline
                            if (spikes == dsd_pkg::SPIKE_MAX) begin
                                ses_phase   = dsd_pkg::PHC_IDLE;
                                fault       = 1'b1;
                                r.event_res = dsd_pkg::EV_FAULT;
                                faulted     = 1'b1;
                            end
                        end
                        if (!faulted && due_reached(due, s.now_tick)) begin
                            r.event_res    = dsd_pkg::EV_VERIFIED;
                            r.begin_weight = start_w;
                            ses_phase      = dsd_pkg::PHC_STABLE;
                        end
                    end
                end
                dsd_pkg::PHC_STABLE: begin
                    if (!s.presence) begin
                        due       = s.now_tick + {16'd0, regs.stop_ticks};
                        ses_phase = dsd_pkg::PHC_STOP;
                    end
                end
                default: begin
                    if (s.presence) begin
                        ses_phase = dsd_pkg::PHC_STABLE;
                    end
                    else if (due_reached(due, s.now_tick)) begin
                        ses_phase = dsd_pkg::PHC_IDLE;
                        drop = {start_w[20], start_w} - {s.weight[20], s.weight};
                        // small or negative drop ends quietly
                        if (!drop[21] && drop[20:0] > {5'd0, regs.intake_threshold}) begin
                            r.event_res    = dsd_pkg::EV_DRINK;
                            r.begin_weight = start_w;
                            r.final_weight = s.weight;
                            r.intake       = drop[20:0];
                        end
                    end
                end
            endcase
            r.phase        = ses_phase;
            r.splash_fault = fault;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, int want_v, int got_v);
            if (want_v != got_v) begin
                mismatch_count++;
                $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
            end
        endfunction

        // m_tdata: [1:0] phase, [3:2] event, [24:4] begin, [45:25] end,
        // [66:46] intake, [67] fault
        function void check_result(logic [71:0] word);
            dsd_pkg::result_t want;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no sample outstanding, expected none got %h",
                         $time, word);
                return;
            end
            want = pending_results.pop_front();
            compare_field("phase", want.phase, word[1:0]);
            compare_field("event_res", want.event_res, word[3:2]);
            compare_field("begin_weight", want.begin_weight, $signed(word[24:4]));
            compare_field("final_weight", want.final_weight, $signed(word[45:25]));
            compare_field("intake", want.intake, word[66:46]);
            compare_field("splash_fault", want.splash_fault, word[67]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    session_scoreboard sb;
    logic [31:0]       tick_now;   // tick value carried between steered samples
    int                tx_burst;   // remaining zero-gap transactions per side
    int                rx_burst;
    int                cycle_count;

    drink_session_detector_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // hard stop in case a handshake never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Random idle gap before each transaction, with occasional back-to-back bursts
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            burst_left = $urandom_range(10, 40);
        return $urandom_range(0, 7);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus tasks. Each one is entered and left right after a rising edge;
    // valid is only lowered when a gap follows, so it never toggles within
    // one step.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic pres, input logic [20:0] w,
                               input logic [31:0] tick);
        int               gap;
        dsd_pkg::sample_t smp;
        gap = draw_gap(tx_burst);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, tick, w, pres};
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        // transaction accepted at this edge
        smp.presence = pres;
        smp.weight   = w;
        smp.now_tick = tick;
        sb.note_sample(smp);
    endtask

    // Pick the next sample from the predicted phase so sessions get past
    // verify most of the time; the rest is breaks, spikes and noise.
    task automatic send_steered();
        int   base;
        int   delta;
        int   off;
        int   roll;
        int   w;
        logic pres;
        base  = sb.start_w;
        delta = sb.regs.splash_delta;
        roll  = $urandom_range(0, 9);
        case (sb.ses_phase)
            dsd_pkg::PHC_IDLE:
            begin
                pres = (roll < 6);
                if ($urandom_range(0, 7) == 0)
                    tick_now = $urandom();
                else
                    tick_now += $urandom_range(0, 50);
                if ($urandom_range(0, 3) == 0)
                    w = $urandom();
                else
                    w = $urandom_range(0, 6000);
            end
            dsd_pkg::PHC_VERIFY:
            begin
                pres = ($urandom_range(0, 19) != 0);
                if (roll < 2)
                    off = delta + $urandom_range(0, 3);
                else if (roll == 2)
                    off = delta;
                else if (roll == 3 && delta > 0)
                    off = delta - 1;
                else if (delta > 1)
                    off = $urandom_range(0, (delta > 40) ? 39 : delta - 1);
                else
                    off = 0;
                if ($urandom_range(0, 1) == 1)
                    off = -off;
                w = base + off;
                case ($urandom_range(0, 9))
                    0:       tick_now = sb.due;
                    1:       tick_now = sb.due - 1;
                    2:       tick_now = $urandom();
                    default: tick_now += $urandom_range(0, int'(sb.regs.dwell_ticks) / 3 + 1);
                endcase
            end
            dsd_pkg::PHC_STABLE:
            begin
                pres = (roll >= 3);
                w    = base - $urandom_range(0, 300);
                tick_now += $urandom_range(0, 100);
            end
            default:
            begin
                pres = (roll == 0);
                case ($urandom_range(0, 5))
                    0:       off = sb.regs.intake_threshold;
                    1:       off = int'(sb.regs.intake_threshold) + 1;
                    2:       off = -$urandom_range(0, 500);
                    3:       off = $urandom();
                    default: off = int'(sb.regs.intake_threshold) + $urandom_range(2, 2000);
                endcase
                w = base - off;
                case ($urandom_range(0, 5))
                    0:       tick_now = sb.due;
                    1:       tick_now = sb.due - 1;
                    default: tick_now += $urandom_range(0, int'(sb.regs.stop_ticks) / 2 + 1);
                endcase
            end
        endcase
        send_sample(pres, 21'(w), tick_now);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_steered();
    endtask

    // Stop the input stream and let every outstanding result drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One write per cycle; write enable drops only after the last one
    task automatic program_regs(input dsd_pkg::cfg_t c);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{dsd_pkg::REG_DWELL, dsd_pkg::REG_STOP, dsd_pkg::REG_SPLASH,
                dsd_pkg::REG_INTAKE};
        val = '{c.dwell_ticks, c.stop_ticks, c.splash_delta, c.intake_threshold};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, check every accepted transaction
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(rx_burst);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1) @(posedge clk);
            sb.check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        dsd_pkg::cfg_t rnd_cfg;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tick_now    = '0;
        tx_burst    = 0;
        rx_burst    = 0;
        cycle_count = 0;
        sb          = new();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset register values ---
        send_sample(1'b0, W_MAX, 32'h0000_0000);        // absent in idle
        // three spikes, the last one past the deadline: fault, no verify
        send_sample(1'b1, 21'd0, 32'd100);
        send_sample(1'b1, 21'd999, 32'd200);
        send_sample(1'b1, 21'd499, 32'd300);            // jump of exactly the delta
        send_sample(1'b1, 21'd999, 32'd5200);
        // new session clears the fault, then presence drops in verify
        send_sample(1'b1, 21'd100, 32'd6000);
        send_sample(1'b0, 21'd100, 32'd6001);
        // deadline wraps past zero; one tick short, then on it
        send_sample(1'b1, 21'd2000, 32'hFFFF_F000);
        send_sample(1'b1, 21'd2010, 32'h0000_0387);
        send_sample(1'b1, 21'd2010, 32'h0000_0388);
        // absence, presence back, absence until stop deadline; drop == threshold
        send_sample(1'b0, 21'd1990, 32'h0000_1000);
        send_sample(1'b1, 21'd1990, 32'h0000_1001);
        send_sample(1'b0, 21'd1990, 32'h0000_2000);
        send_sample(1'b0, 21'd1990, 32'h0000_2BB8);
        // largest possible intake
        send_sample(1'b1, W_MAX, 32'h0000_3000);
        send_sample(1'b1, W_MAX, 32'h0000_4388);
        send_sample(1'b0, W_MAX, 32'h0000_5000);
        send_sample(1'b0, W_MIN, 32'h0000_5BB8);
        // weight rises over the session: negative drop
        send_sample(1'b1, W_MIN, 32'h0000_6000);
        send_sample(1'b1, W_MIN, 32'h0000_8000);
        send_sample(1'b0, W_MIN, 32'h0000_8001);
        send_sample(1'b0, W_MAX, 32'h0000_9000);
        // drop one above the threshold
        send_sample(1'b1, 21'd500, 32'h0000_A000);
        send_sample(1'b1, 21'd500, 32'h0000_C000);
        send_sample(1'b0, 21'd500, 32'h0000_C001);
        send_sample(1'b0, 21'd489, 32'h0000_E000);

        // --- random phases over several register settings ---
        run_random(300);
        settle();
        program_regs('{16'd0, 16'd0, 16'd0, 16'd0});
        run_random(150);
        settle();
        program_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_random(150);
        settle();
        program_regs('{16'd200, 16'd150, 16'd300, 16'd50});
        run_random(350);
        settle();
        rnd_cfg.dwell_ticks      = $urandom_range(0, 65535);
        rnd_cfg.stop_ticks       = $urandom_range(0, 65535);
        rnd_cfg.splash_delta     = $urandom_range(0, 65535);
        rnd_cfg.intake_threshold = $urandom_range(0, 65535);
        program_regs(rnd_cfg);
        run_random(350);
        settle();
        program_regs('{16'd1, 16'd1, 16'd1, 16'd0});
        run_random(200);
        settle();

        if (sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/core/dsd_pkg.sv
rtl/core/dsd_step.sv
rtl/core/drink_session_detector_top.sv
sim/drink_session_detector_top_tb.sv
